// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define BVCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvcp: same-cycle check failed");

// Next-cycle implication
`define BVCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvcp: next-cycle check failed");

`endif

// ===== hw/rtl/bvcp_pkg.sv =====
// ----------------------------------------------------------------------------
// bvcp_pkg
// Shared widths, register map, reset values, state types and field helpers
// for the battery charge percentage block.
// ----------------------------------------------------------------------------
package bvcp_pkg;

    // Field widths
    localparam int unsigned MV_W    = 16;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned POINT_W = MV_W + PCT_W;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned OUT_W   = 8;

    // Table
    localparam int unsigned REG_POINTS     = 7;
    localparam int unsigned MAX_POINTS_DEF = 7;

    // Serial multiply/divide widths
    localparam int unsigned PROD_W = POINT_W;
    localparam int unsigned DVS_W  = MV_W + PCT_W - 1;
    localparam int unsigned STEP_W = $clog2(PCT_W);

    // APB
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;

    // Register map
    localparam logic [CNT_W-1:0] REG_IDX_COUNT = 3'd0;

    // Reset values
    localparam logic [CNT_W-1:0]   COUNT_RST  = 3'd2;
    localparam logic [POINT_W-1:0] POINT0_RST = 23'd537700;
    localparam logic [POINT_W-1:0] POINT1_RST = 23'd422400;

    typedef logic [REG_POINTS-1:0][POINT_W-1:0] point_tab_t;

    // Whole table after reset: first two points set, the rest cleared
    localparam point_tab_t POINTS_RST = {{((REG_POINTS-2)*POINT_W){1'b0}},
                                         POINT1_RST, POINT0_RST};

    // Main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_CALC,
        ST_DONE
    } state_t;

    // Multiply/divide unit sequencer
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_phase_t;

    // Request into the multiply/divide unit
    typedef struct packed {
        logic             start;
        logic [PCT_W-1:0] mag_a;
        logic [MV_W-1:0]  mag_b;
        logic [MV_W-1:0]  divisor;
    } md_req_t;

    // Status back from the multiply/divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

    function automatic logic [MV_W-1:0] pt_mv(input logic [POINT_W-1:0] pt);
        return pt[POINT_W-1:PCT_W];
    endfunction

    function automatic logic [PCT_W-1:0] pt_pct(input logic [POINT_W-1:0] pt);
        return pt[PCT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/bvcp_in_if.sv =====
// ----------------------------------------------------------------------------
// bvcp_in_if
// Voltage sample channel: valid/ready with the millivolt reading.
// ----------------------------------------------------------------------------
interface bvcp_in_if import bvcp_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [MV_W-1:0] millivolts;

    modport source (output valid, output millivolts, input ready);
    modport sink   (input valid, input millivolts, output ready);

endinterface

// ===== hw/rtl/bvcp_out_if.sv =====
// ----------------------------------------------------------------------------
// bvcp_out_if
// Charge result channel: valid/ready with the state-of-charge percentage.
// ----------------------------------------------------------------------------
interface bvcp_out_if import bvcp_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] charge_percent;

    modport source (output valid, output charge_percent, input ready);
    modport sink   (input valid, input charge_percent, output ready);

endinterface

// ===== hw/rtl/bvcp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// bvcp_apb_regs
// APB register file: point count and the seven table points.
// ----------------------------------------------------------------------------
module bvcp_apb_regs import bvcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CNT_W-1:0]      point_count,
    output point_tab_t            points
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    point_tab_t       point_reg;
    point_tab_t       point_next;
    logic             wr_en;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] pt_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign pt_idx = idx - 3'd1;

    // Write decode
    always_comb
    begin
        count_next = count_reg;
        point_next = point_reg;
        if (wr_en)
        begin
            if (idx == REG_IDX_COUNT)
            begin
                count_next = pwdata[CNT_W-1:0];
            end
            else
            begin
                point_next[pt_idx] = pwdata[POINT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RST;
            point_reg <= POINTS_RST;
        end
        else
        begin
            count_reg <= count_next;
            point_reg <= point_next;
        end
    end

    // Read-back
    always_comb
    begin
        if (idx == REG_IDX_COUNT)
        begin
            prdata = APB_DATA_W'(count_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(point_reg[pt_idx]);
        end
    end

    assign point_count = count_reg;
    assign points      = point_reg;

endmodule

// ===== hw/rtl/bvcp_muldiv.sv =====
// ----------------------------------------------------------------------------
// bvcp_muldiv
// Bit-serial unit: shift-add multiply of two magnitudes, then restoring
// division of the product, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvcp_muldiv import bvcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  md_req_t          req,
    output md_stat_t         stat,
    output logic [PCT_W-1:0] quotient
);

    md_phase_t         phase_reg;
    md_phase_t         phase_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [PCT_W-1:0]  mplr_reg;
    logic [PCT_W-1:0]  mplr_next;
    logic [MV_W-1:0]   mcand_reg;
    logic [MV_W-1:0]   mcand_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  dvs_next;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;
    logic [PCT_W-1:0]  quo_reg;
    logic [PCT_W-1:0]  quo_next;
    logic              done_reg;
    logic              done_next;
    logic              ge;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PCT_W - 1);

    // Sequencer next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    phase_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    phase_next = MD_IDLE;
                end
            end
            default: phase_next = MD_IDLE;
        endcase
    end

    // Datapath: one multiplier bit, then one quotient bit, per cycle
    assign ge = (acc_reg >= PROD_W'(dvs_reg));

    always_comb
    begin
        cnt_next   = cnt_reg;
        mplr_next  = mplr_reg;
        mcand_next = mcand_reg;
        dvs_next   = dvs_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    mplr_next  = req.mag_a;
                    mcand_next = req.mag_b;
                    dvs_next   = {req.divisor, {(PCT_W-1){1'b0}}};
                    acc_next   = '0;
                    cnt_next   = LAST_STEP;
                end
            end
            MD_MUL:
            begin
                acc_next  = {acc_reg[PROD_W-2:0], 1'b0}
                          + (mplr_reg[PCT_W-1] ? PROD_W'(mcand_reg) : '0);
                mplr_next = {mplr_reg[PCT_W-2:0], 1'b0};
                cnt_next  = (cnt_reg == '0) ? LAST_STEP : cnt_reg - 1'b1;
            end
            MD_DIV:
            begin
                acc_next = ge ? acc_reg - PROD_W'(dvs_reg) : acc_reg;
                quo_next = {quo_reg[PCT_W-2:0], ge};
                dvs_next = {1'b0, dvs_reg[DVS_W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mplr_reg  <= mplr_next;
        mcand_reg <= mcand_next;
        dvs_reg   <= dvs_next;
        acc_reg   <= acc_next;
        quo_reg   <= quo_next;
    end

    // Status
    always_comb
    begin
        stat.busy = (phase_reg != MD_IDLE);
        stat.done = done_reg;
        quotient  = quo_reg;
    end

endmodule

// ===== hw/rtl/battery_voltage_to_charge_percent.sv =====
// Flow: a clamped voltage goes from the check straight to the result; otherwise the
//   segments are scanned in turn, a flat segment gives its percentage directly and a
//   sloped one runs 7 multiply and 7 divide steps in bvcp_muldiv before the hand-off.
// Requests: one at a time; the next is taken the cycle after the result moves to the
//   output register.
// Reset: rst_n asynchronous; registers return to a two-point 4200 mV / 3300 mV table.
// ----------------------------------------------------------------------------
// battery_voltage_to_charge_percent
// Maps a battery voltage to a state-of-charge percentage by piecewise linear
// interpolation over a configured table of up to seven points.
// ----------------------------------------------------------------------------
module battery_voltage_to_charge_percent import bvcp_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bvcp_in_if.sink               voltage,
    bvcp_out_if.source            charge,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CNT_W-1:0] point_count;
    point_tab_t       points;
    md_req_t          md_req;
    md_stat_t         md_stat;
    logic [PCT_W-1:0] md_quo;

    state_t           state_reg;
    state_t           state_next;
    logic [MV_W-1:0]  mv_reg;
    logic [MV_W-1:0]  mv_next;
    point_tab_t       pts_sh_reg;
    point_tab_t       pts_sh_next;
    logic [CNT_W-1:0] last_reg;
    logic [CNT_W-1:0] last_next;
    logic [CNT_W-1:0] seg_reg;
    logic [CNT_W-1:0] seg_next;
    logic [PCT_W-1:0] p0_reg;
    logic [PCT_W-1:0] p0_next;
    logic             neg_reg;
    logic             neg_next;
    logic [OUT_W-1:0] res_reg;
    logic [OUT_W-1:0] res_next;
    logic [OUT_W-1:0] out_pct_reg;
    logic [OUT_W-1:0] out_pct_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] last_eff;
    logic [MV_W-1:0]  seg_v0;
    logic [MV_W-1:0]  seg_v1;
    logic [PCT_W-1:0] seg_p0;
    logic [PCT_W-1:0] seg_p1;
    logic             seg_hit;
    logic             fast_hi;
    logic             fast_lo;

    bvcp_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .point_count (point_count),
        .points      (points)
    );

    bvcp_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (md_req),
        .stat     (md_stat),
        .quotient (md_quo)
    );

    assign accept   = voltage.valid & voltage.ready;
    assign out_free = !out_valid_reg || charge.ready;

    // Effective last index: count clamped to 2..MAX_POINTS
    always_comb
    begin
        priority if (point_count < 3'd2)
        begin
            last_eff = 3'd1;
        end
        else if (point_count > CNT_W'(MAX_POINTS))
        begin
            last_eff = CNT_W'(MAX_POINTS - 1);
        end
        else
        begin
            last_eff = point_count - 3'd1;
        end
    end

    // Clamp checks against the end points
    assign fast_hi = (mv_reg >= pt_mv(points[0]));
    assign fast_lo = (mv_reg <= pt_mv(points[last_eff]));

    // Current segment sits at the bottom of the shifting copy
    assign seg_v0  = pt_mv(pts_sh_reg[0]);
    assign seg_v1  = pt_mv(pts_sh_reg[1]);
    assign seg_p0  = pt_pct(pts_sh_reg[0]);
    assign seg_p1  = pt_pct(pts_sh_reg[1]);
    assign seg_hit = (mv_reg <= seg_v0) && (mv_reg >= seg_v1);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (voltage.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (fast_hi || fast_lo) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                priority if (seg_hit)
                begin
                    state_next = (seg_v0 == seg_v1) ? ST_DONE : ST_CALC;
                end
                else if (seg_reg + 3'd1 == last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_CALC:
            begin
                if (md_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath
    always_comb
    begin
        voltage.ready  = (state_reg == ST_IDLE);
        mv_next        = mv_reg;
        pts_sh_next    = pts_sh_reg;
        last_next      = last_reg;
        seg_next       = seg_reg;
        p0_next        = p0_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_pct_next   = out_pct_reg;
        out_valid_next = out_valid_reg && !charge.ready;
        md_req.start   = 1'b0;
        md_req.mag_a   = seg_p1 - seg_p0;
        md_req.mag_b   = seg_v0 - mv_reg;
        md_req.divisor = seg_v0 - seg_v1;
        if (seg_p1 < seg_p0)
        begin
            md_req.mag_a = seg_p0 - seg_p1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mv_next     = voltage.millivolts;
                    pts_sh_next = points;
                end
            end
            ST_CHECK:
            begin
                last_next = last_eff;
                seg_next  = '0;
                priority if (fast_hi)
                begin
                    res_next = OUT_W'(pt_pct(points[0]));
                end
                else if (fast_lo)
                begin
                    res_next = OUT_W'(pt_pct(points[last_eff]));
                end
                else
                begin
                    res_next = res_reg;
                end
            end
            ST_SCAN:
            begin
                priority if (seg_hit)
                begin
                    p0_next  = seg_p0;
                    neg_next = (seg_p1 < seg_p0);
                    res_next = OUT_W'(seg_p0);
                    if (seg_v0 != seg_v1)
                    begin
                        md_req.start = 1'b1;
                    end
                end
                else if (seg_reg + 3'd1 == last_reg)
                begin
                    res_next = '0;
                end
                else
                begin
                    seg_next = seg_reg + 3'd1;
                    for (int k = 0; k < REG_POINTS - 1; k++)
                    begin
                        pts_sh_next[k] = pts_sh_reg[k+1];
                    end
                end
            end
            ST_CALC:
            begin
                if (md_stat.done)
                begin
                    res_next = neg_reg ? OUT_W'(p0_reg) - OUT_W'(md_quo)
                                       : OUT_W'(p0_reg) + OUT_W'(md_quo);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_pct_next   = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg      <= mv_next;
        pts_sh_reg  <= pts_sh_next;
        last_reg    <= last_next;
        seg_reg     <= seg_next;
        p0_reg      <= p0_next;
        neg_reg     <= neg_next;
        res_reg     <= res_next;
        out_pct_reg <= out_pct_next;
    end

    assign charge.valid          = out_valid_reg;
    assign charge.charge_percent = out_pct_reg;

    // Checks
`include "assert_macros.svh"

    `BVCP_ASSERT_NXT(a_accept_to_check, accept, state_reg == ST_CHECK)
    `BVCP_ASSERT_IMP(a_scan_in_range, state_reg == ST_SCAN, seg_reg < last_reg)
    `BVCP_ASSERT_IMP(a_md_done_in_calc, md_stat.done, state_reg == ST_CALC)
    `BVCP_ASSERT_IMP(a_md_start_idle, md_req.start, !md_stat.busy)
    `BVCP_ASSERT_NXT(a_result_held, state_reg == ST_DONE && !out_free, $stable(res_reg))

endmodule
